### design/pip_pkg.sv
// Package for the point-in-polygon tester: sizes, command and status codes,
// and the word, vertex and edge struct types used across the modules.
// No dependencies.
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] vertex_count;
    logic [1:0]       status;
  } out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vertex_t;

  // One edge handed to the crossing unit: a is vertex i, b is vertex j.
  typedef struct packed {
    logic    valid;
    vertex_t a;
    vertex_t b;
  } edge_req_t;

  typedef struct packed {
    logic busy;
    logic toggle_vld;
    logic toggle;
  } edge_sts_t;

endpackage

### design/pip_vert_mem.sv
// Vertex table: one write port and one read port with registered read data.
// Depends on pip_pkg.
module pip_vert_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [pip_pkg::IDX_W-1:0]     waddr_i,
  input  pip_pkg::vertex_t              wdata_i,
  input  logic                          re_i,
  input  logic [pip_pkg::IDX_W-1:0]     raddr_i,
  output pip_pkg::vertex_t              rdata_o
);
  import pip_pkg::*;

  vertex_t mem_q [MAX_VERTICES];
  vertex_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/pip_edge_unit.sv
// Three-stage edge crossing unit: differences, products, then the signed
// compare with the half-open y span. Depends on pip_pkg.
module pip_edge_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pip_pkg::edge_req_t              req_i,
  input  logic signed [pip_pkg::COORD_BITS-1:0] px_i,
  input  logic signed [pip_pkg::COORD_BITS-1:0] py_i,
  output pip_pkg::edge_sts_t              sts_o
);
  import pip_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic span1_q, span2_q;
  logic neg1_q, neg2_q;
  logic tog3_q;
  logic signed [DIFF_W-1:0] dxp_q, dy_q, dxe_q, dyp_q;
  logic signed [PROD_W-1:0] lhs_q, rhs_q;
  logic span_d;
  logic signed [DIFF_W-1:0] dy_d;

  always_comb begin
    span_d = ((req_i.a.y <= py_i) && (py_i < req_i.b.y)) ||
             ((req_i.b.y <= py_i) && (py_i < req_i.a.y));
    dy_d   = DIFF_W'(req_i.b.y) - DIFF_W'(req_i.a.y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    span1_q <= span_d;
    neg1_q  <= dy_d[DIFF_W-1];
    dxp_q   <= DIFF_W'(px_i) - DIFF_W'(req_i.a.x);
    dy_q    <= dy_d;
    dxe_q   <= DIFF_W'(req_i.b.x) - DIFF_W'(req_i.a.x);
    dyp_q   <= DIFF_W'(py_i) - DIFF_W'(req_i.a.y);

    span2_q <= span1_q;
    neg2_q  <= neg1_q;
    lhs_q   <= PROD_W'(dxp_q) * PROD_W'(dy_q);
    rhs_q   <= PROD_W'(dxe_q) * PROD_W'(dyp_q);

    // Negating both sides for a falling edge flips the compare.
    tog3_q  <= span2_q && (neg2_q ? (lhs_q > rhs_q) : (lhs_q < rhs_q));
  end

  assign sts_o.busy       = v1_q | v2_q | v3_q;
  assign sts_o.toggle_vld = v3_q;
  assign sts_o.toggle     = tog3_q;

endmodule

### design/point_in_polygon_test.sv
// Point-in-polygon tester, top level: command sequencer, bounding box and
// result register. Depends on pip_pkg, pip_vert_mem and pip_edge_unit.
//
// Each input word carries a command: clear, append a vertex, or test a point.
// Clear, append, unused codes, a test on an empty table and a test outside the
// bounding box give their result word in the cycle after acceptance. A test
// inside the box walks the vertex memory once, starting with the last vertex
// for the closing edge, so it reads N+1 entries for N stored vertices through
// the memory's single read port, then drains the three-stage crossing unit
// before its result word is given. One word is processed at a time. A
// result held by a stall on the output also stalls the input, and the next
// word can be taken in the same cycle that the waiting result is taken.
module point_in_polygon_test (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pip_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pip_pkg::out_t out_data_o
);
  import pip_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic signed [COORD_BITS-1:0] min_x_q, min_x_d, max_x_q, max_x_d;
  logic signed [COORD_BITS-1:0] min_y_q, min_y_d, max_y_q, max_y_d;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [IDX_W-1:0] rd_addr_q, rd_addr_d, last_idx;
  logic rd_first_q, rd_first_d;
  logic rd_vld_q, data_first_q;
  logic parity_q, parity_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  vertex_t prev_q, rd_data, wr_data;

  logic in_accept, out_free, in_box, mem_we, rd_en;
  logic [CNT_W-1:0] count_m1;
  edge_req_t edge_req;
  edge_sts_t edge_sts;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) | ~out_free;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign count_m1 = count_q - CNT_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];
  assign wr_data  = '{x: in_data_i.coord_x, y: in_data_i.coord_y};

  always_comb begin
    in_box = (in_data_i.coord_x >= min_x_q) && (in_data_i.coord_x <= max_x_q) &&
             (in_data_i.coord_y >= min_y_q) && (in_data_i.coord_y <= max_y_q);
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    min_x_d     = min_x_q;
    max_x_d     = max_x_q;
    min_y_d     = min_y_q;
    max_y_d     = max_y_q;
    rd_addr_d   = rd_addr_q;
    rd_first_d  = rd_first_q;
    parity_d    = parity_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    rd_en       = 1'b0;

    if (edge_sts.toggle_vld) begin
      parity_d = parity_q ^ edge_sts.toggle;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          out_valid_d = 1'b1;
          out_d = '{inside_res: 1'b0, vertex_count: count_q, status: STS_OK};
          case (in_data_i.command)
            CMD_CLEAR: begin
              count_d = '0;
              min_x_d = '0;
              max_x_d = '0;
              min_y_d = '0;
              max_y_d = '0;
              out_d.vertex_count = '0;
            end
            CMD_APPEND: begin
              if (count_q >= CNT_W'(MAX_VERTICES)) begin
                out_d.status = STS_FULL;
              end else begin
                mem_we = 1'b1;
                if (count_q == '0) begin
                  min_x_d = in_data_i.coord_x;
                  max_x_d = in_data_i.coord_x;
                  min_y_d = in_data_i.coord_y;
                  max_y_d = in_data_i.coord_y;
                end else begin
                  if (in_data_i.coord_x < min_x_q) min_x_d = in_data_i.coord_x;
                  if (in_data_i.coord_x > max_x_q) max_x_d = in_data_i.coord_x;
                  if (in_data_i.coord_y < min_y_q) min_y_d = in_data_i.coord_y;
                  if (in_data_i.coord_y > max_y_q) max_y_d = in_data_i.coord_y;
                end
                count_d = count_q + CNT_W'(1);
                out_d.vertex_count = count_q + CNT_W'(1);
              end
            end
            CMD_TEST: begin
              if (count_q == '0) begin
                out_d.status = STS_EMPTY;
              end else if (in_box) begin
                // The first read fetches the last vertex for the closing edge.
                out_valid_d = 1'b0;
                state_d     = ST_RUN;
                rd_addr_d   = last_idx;
                rd_first_d  = 1'b1;
                parity_d    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        rd_en = 1'b1;
        if (rd_first_q) begin
          rd_addr_d  = '0;
          rd_first_d = 1'b0;
        end else begin
          rd_addr_d = rd_addr_q + IDX_W'(1);
          if (rd_addr_q == last_idx) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !edge_sts.busy && out_free) begin
          out_valid_d = 1'b1;
          out_d = '{inside_res: parity_q, vertex_count: count_q, status: STS_OK};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      min_x_q     <= '0;
      max_x_q     <= '0;
      min_y_q     <= '0;
      max_y_q     <= '0;
      rd_first_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      min_x_q     <= min_x_d;
      max_x_q     <= max_x_d;
      min_y_q     <= min_y_d;
      max_y_q     <= max_y_d;
      rd_first_q  <= rd_first_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q    <= rd_addr_d;
    parity_q     <= parity_d;
    out_q        <= out_d;
    data_first_q <= rd_first_q;
    if (in_accept) begin
      px_q <= in_data_i.coord_x;
      py_q <= in_data_i.coord_y;
    end
    if (rd_vld_q) begin
      prev_q <= rd_data;
    end
  end

  // Each returned vertex after the first closes an edge with the one read just before it.
  assign edge_req.valid = rd_vld_q & ~data_first_q;
  assign edge_req.a     = rd_data;
  assign edge_req.b     = prev_q;

  pip_vert_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  pip_edge_unit u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (edge_req),
    .px_i   (px_q),
    .py_i   (py_q),
    .sts_o  (edge_sts)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input accepted while a test is running");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count exceeds table size");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (!rd_en && !rd_vld_q && !edge_sts.busy))
    else $error("vertex write while a walk is in flight");

endmodule
